// ===== design/tcse_pkg.sv =====
// ----------------------------------------------------------------------------
// Telnet client stream engine package
// Protocol byte codes, input action codes and the reply job descriptor that
// the parser hands to the emitter.
// ----------------------------------------------------------------------------
package tcse_pkg;

    // Telnet command and option bytes.
    localparam logic [7:0] BYTE_IAC     = 8'hFF;
    localparam logic [7:0] BYTE_DONT    = 8'hFE;
    localparam logic [7:0] BYTE_DO      = 8'hFD;
    localparam logic [7:0] BYTE_WONT    = 8'hFC;
    localparam logic [7:0] BYTE_WILL    = 8'hFB;
    localparam logic [7:0] BYTE_SB      = 8'hFA;
    localparam logic [7:0] BYTE_SE      = 8'hF0;
    localparam logic [7:0] OPTION_ECHO  = 8'h01;
    localparam logic [7:0] OPTION_SGA   = 8'h03;
    localparam logic [7:0] OPTION_NAWS  = 8'h1F;

    // Input action codes.
    localparam logic [2:0] ACT_RECEIVE    = 3'd0;
    localparam logic [2:0] ACT_TRANSMIT   = 3'd1;
    localparam logic [2:0] ACT_CONNECT    = 3'd2;
    localparam logic [2:0] ACT_RESIZE     = 3'd3;
    localparam logic [2:0] ACT_DISCONNECT = 3'd4;

    // Steps of the reply program. A job plays a contiguous run of them.
    typedef enum logic [4:0] {
        SL_CMD_IAC   = 5'd0,
        SL_CMD_VERB  = 5'd1,
        SL_CMD_OPT   = 5'd2,
        SL_NAWS_IAC  = 5'd3,
        SL_NAWS_SB   = 5'd4,
        SL_NAWS_OPT  = 5'd5,
        SL_COLS_HI   = 5'd6,
        SL_COLS_LO   = 5'd7,
        SL_ROWS_HI   = 5'd8,
        SL_ROWS_LO   = 5'd9,
        SL_NAWS_IAC2 = 5'd10,
        SL_NAWS_SE   = 5'd11,
        SL_ECHO_IAC  = 5'd12,
        SL_ECHO_DO   = 5'd13,
        SL_ECHO_OPT  = 5'd14,
        SL_SGA_IAC   = 5'd15,
        SL_SGA_DO    = 5'd16,
        SL_SGA_OPT   = 5'd17,
        SL_DATA      = 5'd18
    } slot_t;

    typedef struct packed {
        slot_t       first_slot;
        slot_t       last_slot;
        logic        net;      // data step goes to the network
        logic        esc_en;   // data step doubles 0xFF
        logic [7:0]  data;
        logic [7:0]  verb;
        logic [7:0]  opt;
    } job_t;

endpackage

// ===== design/telnet_client_stream_engine.sv =====
// Telnet client stream engine. Each input word is one action (received byte,
// transmit byte, connect, resize or disconnect) and yields a run of zero to 22
// output words, the final one marked by tlast and tuser telling network bytes
// from terminal bytes. Parser and link state are updated as a word is
// accepted, and its reply is played out by a sequencer at one byte per cycle,
// while the sink takes them, through a single output word register. After a
// word is taken, s_axis_tready stays low until the last byte of its run is
// loaded, so plain data and empty runs go at one word per cycle while the
// output is not stalled.
// ----------------------------------------------------------------------------
// Telnet client stream engine: top level
// Joins the IAC parser and the reply emitter to the stream ports.
// ----------------------------------------------------------------------------
module telnet_client_stream_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte [7:0], columns [23:8], rows [39:24]
    input  logic [2:0]  s_axis_tuser,   // action [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    output logic        m_axis_tuser,   // to_network [0]
    output logic        m_axis_tlast
);
    import tcse_pkg::*;

    logic        accept;
    logic        job_ready;
    logic        job_valid;
    job_t        job;
    logic [15:0] window_cols;
    logic [15:0] window_rows;

    assign s_axis_tready = job_ready;
    assign accept        = s_axis_tvalid && job_ready;

    tcse_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (s_axis_tuser),
        .data_byte   (s_axis_tdata[7:0]),
        .columns     (s_axis_tdata[23:8]),
        .rows        (s_axis_tdata[39:24]),
        .job         (job),
        .job_valid   (job_valid),
        .window_cols (window_cols),
        .window_rows (window_rows)
    );

    tcse_emitter u_emitter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_start   (accept && job_valid),
        .job         (job),
        .window_cols (window_cols),
        .window_rows (window_rows),
        .job_ready   (job_ready),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast)
    );

endmodule

// ===== design/tcse_parser.sv =====
// ----------------------------------------------------------------------------
// Telnet client stream engine: parser
// Holds the IAC parser, link and window state, and turns each accepted word
// into at most one reply job for the emitter.
// ----------------------------------------------------------------------------
module tcse_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [2:0]      action,
    input  logic [7:0]      data_byte,
    input  logic [15:0]     columns,
    input  logic [15:0]     rows,
    output tcse_pkg::job_t  job,
    output logic            job_valid,
    output logic [15:0]     window_cols,
    output logic [15:0]     window_rows
);
    import tcse_pkg::*;

    typedef enum logic [4:0] {
        PS_NORMAL = 5'b00001,
        PS_IAC    = 5'b00010,
        PS_VERB   = 5'b00100,
        PS_SUB    = 5'b01000,
        PS_SUBIAC = 5'b10000
    } parse_state_t;

    parse_state_t parse_state_reg, parse_state_next;
    logic [7:0]   pending_verb_reg, pending_verb_next;
    logic [15:0]  window_cols_reg, window_cols_next;
    logic [15:0]  window_rows_reg, window_rows_next;
    logic         link_open_reg, link_open_next;

    // Maps a pending verb to a small selector: DO, WILL, DONT, otherwise WONT.
    function automatic logic [1:0] pending_verb_r_sel(input logic [7:0] verb);
        logic [1:0] sel;
        begin
            if (verb == BYTE_DO)
                sel = 2'd0;
            else if (verb == BYTE_WILL)
                sel = 2'd1;
            else if (verb == BYTE_DONT)
                sel = 2'd2;
            else
                sel = 2'd3;
            return sel;
        end
    endfunction

    always_comb
    begin
        parse_state_next  = parse_state_reg;
        pending_verb_next = pending_verb_reg;
        window_cols_next  = window_cols_reg;
        window_rows_next  = window_rows_reg;
        link_open_next    = link_open_reg;

        job_valid      = 1'b0;
        job.first_slot = SL_DATA;
        job.last_slot  = SL_DATA;
        job.net        = 1'b0;
        job.esc_en     = 1'b0;
        job.data       = data_byte;
        job.verb       = BYTE_WILL;
        job.opt        = OPTION_NAWS;

        case (action)
            ACT_RECEIVE:
            begin
                if (link_open_reg)
                begin
                    case (parse_state_reg)
                        PS_IAC:
                        begin
                            if (data_byte == BYTE_IAC)
                            begin
                                job_valid        = 1'b1;
                                parse_state_next = PS_NORMAL;
                            end
                            else if (data_byte == BYTE_SB)
                            begin
                                parse_state_next = PS_SUB;
                            end
                            else if (data_byte inside {BYTE_WILL, BYTE_WONT,
                                                       BYTE_DO, BYTE_DONT})
                            begin
                                pending_verb_next = data_byte;
                                parse_state_next  = PS_VERB;
                            end
                            else
                            begin
                                parse_state_next = PS_NORMAL;
                            end
                        end
                        PS_VERB:
                        begin
                            parse_state_next = PS_NORMAL;
                            job.first_slot   = SL_CMD_IAC;
                            job.last_slot    = SL_CMD_OPT;
                            job.opt          = data_byte;
                            job_valid        = 1'b1;
                            case (pending_verb_r_sel(pending_verb_reg))
                                2'd0:
                                begin
                                    // DO: offer NAWS with the window size, refuse the rest.
                                    if (data_byte == OPTION_NAWS)
                                    begin
                                        job.verb      = BYTE_WILL;
                                        job.last_slot = SL_NAWS_SE;
                                    end
                                    else
                                    begin
                                        job.verb = BYTE_WONT;
                                    end
                                end
                                2'd1:
                                begin
                                    if (data_byte == OPTION_ECHO || data_byte == OPTION_SGA)
                                        job.verb = BYTE_DO;
                                    else
                                        job.verb = BYTE_DONT;
                                end
                                2'd2:    job.verb = BYTE_WONT;
                                default: job.verb = BYTE_DONT;
                            endcase
                            if (!(pending_verb_reg inside {BYTE_WILL, BYTE_WONT,
                                                            BYTE_DO, BYTE_DONT}))
                                job_valid = 1'b0;
                        end
                        PS_SUB:
                        begin
                            if (data_byte == BYTE_IAC)
                                parse_state_next = PS_SUBIAC;
                        end
                        PS_SUBIAC:
                        begin
                            parse_state_next = (data_byte == BYTE_IAC) ? PS_SUB : PS_NORMAL;
                        end
                        default:
                        begin
                            if (data_byte == BYTE_IAC)
                            begin
                                parse_state_next = PS_IAC;
                            end
                            else
                            begin
                                parse_state_next = PS_NORMAL;
                                job_valid        = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ACT_TRANSMIT:
            begin
                job_valid  = link_open_reg;
                job.net    = 1'b1;
                job.esc_en = 1'b1;
            end
            ACT_CONNECT:
            begin
                parse_state_next = PS_NORMAL;
                link_open_next   = 1'b1;
                job_valid        = 1'b1;
                job.first_slot   = SL_CMD_IAC;
                job.last_slot    = SL_SGA_OPT;
            end
            ACT_RESIZE:
            begin
                window_cols_next = columns;
                window_rows_next = rows;
                job_valid        = link_open_reg;
                job.first_slot   = SL_NAWS_IAC;
                job.last_slot    = SL_NAWS_SE;
            end
            ACT_DISCONNECT:
            begin
                link_open_next = 1'b0;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg  <= PS_NORMAL;
            pending_verb_reg <= 8'h00;
            window_cols_reg  <= 16'd80;
            window_rows_reg  <= 16'd24;
            link_open_reg    <= 1'b0;
        end
        else if (accept)
        begin
            parse_state_reg  <= parse_state_next;
            pending_verb_reg <= pending_verb_next;
            window_cols_reg  <= window_cols_next;
            window_rows_reg  <= window_rows_next;
            link_open_reg    <= link_open_next;
        end
    end

    assign window_cols = window_cols_reg;
    assign window_rows = window_rows_reg;

endmodule

// ===== design/tcse_emitter.sv =====
// ----------------------------------------------------------------------------
// Telnet client stream engine: emitter
// Holds one reply job and plays it out a byte per cycle, while the sink is ready,
// into the output word register, doubling 0xFF where the protocol calls for it.
// ----------------------------------------------------------------------------
module tcse_emitter
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_start,
    input  tcse_pkg::job_t  job,
    input  logic [15:0]     window_cols,
    input  logic [15:0]     window_rows,
    output logic            job_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);
    import tcse_pkg::*;

    logic        job_valid_reg;
    job_t        job_reg;
    slot_t       slot_reg;
    logic        esc_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_net_reg;
    logic        out_last_reg;

    logic [7:0]  cur_byte;
    logic        cur_net;
    logic        esc_slot;
    logic        esc_pending;
    logic        cur_last;
    logic        load;

    always_comb
    begin
        cur_net = 1'b1;
        case (slot_reg)
            SL_CMD_IAC, SL_NAWS_IAC, SL_NAWS_IAC2,
            SL_ECHO_IAC, SL_SGA_IAC:  cur_byte = BYTE_IAC;
            SL_CMD_VERB:              cur_byte = job_reg.verb;
            SL_CMD_OPT:               cur_byte = job_reg.opt;
            SL_NAWS_SB:               cur_byte = BYTE_SB;
            SL_NAWS_OPT:              cur_byte = OPTION_NAWS;
            SL_COLS_HI:               cur_byte = window_cols[15:8];
            SL_COLS_LO:               cur_byte = window_cols[7:0];
            SL_ROWS_HI:               cur_byte = window_rows[15:8];
            SL_ROWS_LO:               cur_byte = window_rows[7:0];
            SL_NAWS_SE:               cur_byte = BYTE_SE;
            SL_ECHO_DO, SL_SGA_DO:    cur_byte = BYTE_DO;
            SL_ECHO_OPT:              cur_byte = OPTION_ECHO;
            SL_SGA_OPT:               cur_byte = OPTION_SGA;
            SL_DATA:
            begin
                cur_byte = job_reg.data;
                cur_net  = job_reg.net;
            end
            default:                  cur_byte = BYTE_IAC;
        endcase

        esc_slot = (slot_reg inside {SL_COLS_HI, SL_COLS_LO, SL_ROWS_HI, SL_ROWS_LO})
                   || (slot_reg == SL_DATA && job_reg.esc_en);
        // The first of a doubled 0xFF keeps the step; the second one moves on.
        esc_pending = esc_slot && (cur_byte == BYTE_IAC) && !esc_reg;
        cur_last    = (slot_reg == job_reg.last_slot) && !esc_pending;
        load        = job_valid_reg && (!out_valid_reg || m_tready);
    end

    assign job_ready = !job_valid_reg || (load && cur_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            esc_reg       <= 1'b0;
        end
        else if (job_start)
        begin
            job_valid_reg <= 1'b1;
            esc_reg       <= 1'b0;
        end
        else if (load)
        begin
            esc_reg <= esc_pending;
            if (cur_last)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_start)
        begin
            job_reg  <= job;
            slot_reg <= job.first_slot;
        end
        else if (load && !esc_pending && !cur_last)
        begin
            slot_reg <= slot_t'(slot_reg + 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            out_net_reg  <= cur_net;
            out_last_reg <= cur_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_net_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_start_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        job_start |-> job_ready)
        else $error("reply job started while the previous one is still playing");

    a_esc_inside_job: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> job_valid_reg)
        else $error("escape phase held without an active job");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (slot_reg <= job_reg.last_slot))
        else $error("reply step ran past the end of its job");

    a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cur_last) |=> job_valid_reg)
        else $error("job dropped before its final word was loaded");
`endif

endmodule

// ===== tb/telnet_client_stream_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telnet client stream engine checker
// Watches the input and output stream channels. Every accepted input word is
// run through a model of the IAC parser, link state and reply policy, and
// the bytes it should produce are queued. Every accepted output word is
// compared field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
module telnet_client_stream_engine_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte [7:0], columns [23:8], rows [39:24]
    input  logic [2:0]  s_axis_tuser,   // action [2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    input  logic        m_axis_tuser,   // to_network [0]
    input  logic        m_axis_tlast,
    output int          words_due,
    output int          mismatches
);

    import tcse_pkg::*;

    typedef enum logic [2:0] {
        RX_DATA    = 3'd0,
        RX_IAC     = 3'd1,
        RX_VERB    = 3'd2,
        RX_SUB     = 3'd3,
        RX_SUB_IAC = 3'd4
    } rx_state_t;

    typedef struct {
        logic       net;
        logic [7:0] value;
        logic       tail;
    } out_word_t;

    out_word_t   reply_q[$];
    rx_state_t   rx_state   = RX_DATA;
    logic [7:0]  held_verb  = 8'd0;
    logic [15:0] win_cols   = 16'd80;
    logic [15:0] win_rows   = 16'd24;
    logic        link_open  = 1'b0;
    int          due_count  = 0;
    int          fail_tally = 0;

    assign words_due  = due_count;
    assign mismatches = fail_tally;

    function automatic void queue_word(input logic net, input logic [7:0] value);
        out_word_t w;
        w.net   = net;
        w.value = value;
        w.tail  = 1'b0;
        reply_q.push_back(w);
    endfunction

    function automatic void queue_escaped(input logic [7:0] value);
        queue_word(1'b1, value);
        if (value == BYTE_IAC)
            queue_word(1'b1, BYTE_IAC);
    endfunction

    function automatic void queue_command(input logic [7:0] verb, input logic [7:0] opt);
        queue_word(1'b1, BYTE_IAC);
        queue_word(1'b1, verb);
        queue_word(1'b1, opt);
    endfunction

    function automatic void queue_window_size();
        queue_word(1'b1, BYTE_IAC);
        queue_word(1'b1, BYTE_SB);
        queue_word(1'b1, OPTION_NAWS);
        queue_escaped(win_cols[15:8]);
        queue_escaped(win_cols[7:0]);
        queue_escaped(win_rows[15:8]);
        queue_escaped(win_rows[7:0]);
        queue_word(1'b1, BYTE_IAC);
        queue_word(1'b1, BYTE_SE);
    endfunction

    // Fixed policy: we let the peer echo and suppress go-ahead, we offer
    // the window size, and everything else is refused.
    function automatic void answer_negotiation(input logic [7:0] verb, input logic [7:0] opt);
        case (verb)
            BYTE_DO:
            begin
                if (opt == OPTION_NAWS)
                begin
                    queue_command(BYTE_WILL, OPTION_NAWS);
                    queue_window_size();
                end
                else
                    queue_command(BYTE_WONT, opt);
            end
            BYTE_WILL:
            begin
                if (opt == OPTION_ECHO || opt == OPTION_SGA)
                    queue_command(BYTE_DO, opt);
                else
                    queue_command(BYTE_DONT, opt);
            end
            BYTE_DONT: queue_command(BYTE_WONT, opt);
            BYTE_WONT: queue_command(BYTE_DONT, opt);
            default: ;
        endcase
    endfunction

    function automatic void parse_received(input logic [7:0] b);
        case (rx_state)
            RX_IAC:
            begin
                if (b == BYTE_IAC)
                begin
                    queue_word(1'b0, BYTE_IAC);
                    rx_state = RX_DATA;
                end
                else if (b == BYTE_SB)
                    rx_state = RX_SUB;
                else if (b == BYTE_WILL || b == BYTE_WONT || b == BYTE_DO || b == BYTE_DONT)
                begin
                    held_verb = b;
                    rx_state  = RX_VERB;
                end
                else
                    rx_state = RX_DATA;
            end
            RX_VERB:
            begin
                answer_negotiation(held_verb, b);
                rx_state = RX_DATA;
            end
            RX_SUB:
            begin
                if (b == BYTE_IAC)
                    rx_state = RX_SUB_IAC;
            end
            RX_SUB_IAC:
                rx_state = (b == BYTE_IAC) ? RX_SUB : RX_DATA;
            default:
            begin
                if (b == BYTE_IAC)
                    rx_state = RX_IAC;
                else
                begin
                    rx_state = RX_DATA;
                    queue_word(1'b0, b);
                end
            end
        endcase
    endfunction

    function automatic void predict_reply(input logic [2:0] act, input logic [7:0] b,
                                          input logic [15:0] cols, input logic [15:0] rows);
        int first_new;
        first_new = reply_q.size();
        case (act)
            ACT_RECEIVE:
            begin
                if (link_open)
                    parse_received(b);
            end
            ACT_TRANSMIT:
            begin
                if (link_open)
                    queue_escaped(b);
            end
            ACT_CONNECT:
            begin
                rx_state  = RX_DATA;
                link_open = 1'b1;
                queue_command(BYTE_WILL, OPTION_NAWS);
                queue_window_size();
                queue_command(BYTE_DO, OPTION_ECHO);
                queue_command(BYTE_DO, OPTION_SGA);
            end
            ACT_RESIZE:
            begin
                win_cols = cols;
                win_rows = rows;
                if (link_open)
                    queue_window_size();
            end
            ACT_DISCONNECT:
                link_open = 1'b0;
            default: ;
        endcase
        if (reply_q.size() > first_new)
            reply_q[reply_q.size() - 1].tail = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_word_t want;
        if (!rst_n)
        begin
            rx_state  = RX_DATA;
            held_verb = 8'd0;
            win_cols  = 16'd80;
            win_rows  = 16'd24;
            link_open = 1'b0;
            reply_q.delete();
            due_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_reply(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                              s_axis_tdata[39:24]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected word: to_network %0d, out_byte 0x%02h, last %0d",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_tally++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_axis_tuser !== want.net)
                    begin
                        $error("to_network: expected %0d, actual %0d", want.net, m_axis_tuser);
                        fail_tally++;
                    end
                    if (m_axis_tdata !== want.value)
                    begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.value, m_axis_tdata);
                        fail_tally++;
                    end
                    if (m_axis_tlast !== want.tail)
                    begin
                        $error("last: expected %0d, actual %0d", want.tail, m_axis_tlast);
                        fail_tally++;
                    end
                end
            end
            due_count <= reply_q.size();
        end
    end

endmodule

// ===== tb/telnet_client_stream_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telnet client stream engine testbench
// Drives a short directed sequence through the engine, then random telnet
// traffic made mostly of well-formed command, negotiation and subnegotiation
// sequences, in phases with and without idling on either side. A separate
// checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module telnet_client_stream_engine_test;

    import tcse_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 128;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;

    localparam logic [7:0] CMD_NOP = 8'hF1;
    localparam logic [7:0] CMD_GA  = 8'hF9;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = 40'd0;   // data_byte [7:0], columns [23:8], rows [39:24]
    logic [2:0]  s_axis_tuser  = 3'd0;    // action [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // out_byte [7:0]
    logic        m_axis_tuser;            // to_network [0]
    logic        m_axis_tlast;

    int words_due;
    int mismatches;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int live_words     = 0;
    int quiet_cycles   = 0;
    bit link_up        = 1'b0;

    telnet_client_stream_engine DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    telnet_client_stream_engine_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .words_due     (words_due),
        .mismatches    (mismatches)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Give up once nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input logic [2:0] act, input logic [7:0] value,
                             input logic [15:0] cols, input logic [15:0] rows);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 3'($urandom);
            s_axis_tdata  <= {8'($urandom), 32'($urandom)};
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {rows, cols, value};
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (act)
            ACT_RECEIVE, ACT_TRANSMIT:
            begin
                if (link_up)
                    live_words++;
            end
            ACT_CONNECT:
            begin
                link_up = 1'b1;
                live_words++;
            end
            ACT_RESIZE:
                live_words++;
            ACT_DISCONNECT:
            begin
                link_up = 1'b0;
                live_words++;
            end
            default: ;
        endcase
    endtask

    task automatic rx(input logic [7:0] value);
        send_word(ACT_RECEIVE, value, 16'($urandom), 16'($urandom));
    endtask

    task automatic tx(input logic [7:0] value);
        send_word(ACT_TRANSMIT, value, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    // Window sizes lean towards 0xFF bytes so that escaping is hit often.
    function automatic logic [15:0] window_value();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        lo = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        return {hi, lo};
    endfunction

    function automatic logic [7:0] option_value();
        case ($urandom_range(3))
            0:       return OPTION_ECHO;
            1:       return OPTION_SGA;
            2:       return OPTION_NAWS;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] verb_value();
        case ($urandom_range(3))
            0:       return BYTE_DO;
            1:       return BYTE_DONT;
            2:       return BYTE_WILL;
            default: return BYTE_WONT;
        endcase
    endfunction

    task automatic random_episode();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (!link_up)
        begin
            if (pick < 60)
                send_word(ACT_CONNECT, 8'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 72)
                rx(8'($urandom));
            else if (pick < 84)
                tx(8'($urandom));
            else if (pick < 94)
                send_word(ACT_RESIZE, 8'($urandom), window_value(), window_value());
            else
                send_word(3'($urandom_range(7, 5)), 8'($urandom), 16'($urandom),
                          16'($urandom));
        end
        else if (pick < 20)
            rx(8'($urandom_range(254)));
        else if (pick < 40)
        begin
            rx(BYTE_IAC);
            rx(verb_value());
            rx(option_value());
        end
        else if (pick < 45)
        begin
            rx(BYTE_IAC);
            rx(BYTE_IAC);
        end
        else if (pick < 52)
        begin
            rx(BYTE_IAC);
            rx($urandom_range(1) ? 8'($urandom_range(CMD_GA, BYTE_SE))
                                 : 8'($urandom_range(BYTE_SE - 1)));
        end
        else if (pick < 62)
        begin
            rx(BYTE_IAC);
            rx(BYTE_SB);
            len = $urandom_range(4);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    rx(BYTE_IAC);
                    rx(BYTE_IAC);
                end
                else
                    rx(8'($urandom_range(254)));
            end
            rx(BYTE_IAC);
            rx(($urandom_range(4) != 0) ? BYTE_SE : 8'($urandom_range(254)));
        end
        else if (pick < 77)
            tx($urandom_range(1) ? BYTE_IAC : 8'($urandom));
        else if (pick < 85)
            send_word(ACT_RESIZE, 8'($urandom), window_value(), window_value());
        else if (pick < 88)
            send_word(ACT_CONNECT, 8'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 91)
        begin
            // Sometimes drop the link in the middle of a command.
            if ($urandom_range(1))
                rx(BYTE_IAC);
            send_word(ACT_DISCONNECT, 8'($urandom), 16'($urandom), 16'($urandom));
        end
        else if (pick < 95)
            send_word(3'($urandom_range(7, 5)), 8'($urandom), 16'($urandom),
                      16'($urandom));
        else
            rx(8'($urandom));
    endtask

    initial
    begin
        int target;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: closed-link cases, connect bursts, parser corners.
        rx(8'h41);
        tx(BYTE_IAC);
        send_word(ACT_RESIZE, 8'h00, 16'hFFFF, 16'hFFFF);
        send_word(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_word(ACT_CONNECT, 8'h00, 16'h0000, 16'h0000);
        send_word(ACT_CONNECT, 8'hFF, 16'hFFFF, 16'hFFFF);
        rx(8'h00);
        rx(BYTE_IAC);
        rx(8'h00);
        rx(BYTE_IAC);
        rx(BYTE_DO);
        rx(OPTION_NAWS);
        rx(BYTE_IAC);
        rx(BYTE_WILL);
        rx(OPTION_ECHO);
        rx(BYTE_IAC);
        rx(BYTE_SB);
        rx(BYTE_IAC);
        rx(8'h41);
        rx(BYTE_DONT);
        tx(BYTE_IAC);
        send_word(ACT_RESIZE, 8'h00, 16'h00FF, 16'hFF00);
        rx(BYTE_IAC);
        send_word(ACT_DISCONNECT, 8'h00, 16'h0000, 16'h0000);
        send_word(ACT_CONNECT, 8'h00, 16'h0000, 16'h0000);
        rx(CMD_NOP);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 64;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 64;
                    drain_replies();
                end
                default:
                begin
                    src_idle_pct   = 33;
                    sink_stall_pct = 33;
                end
            endcase
            target = live_words + RANDOM_WORDS / 4;
            while (live_words < target)
                random_episode();
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
